// ===== design/hrbp_pkg.sv =====
// Package for the HTTP request byte parser: payload structs of both channels,
// the output code points and the configuration register indexes and reset values. No dependencies.

package hrbp_pkg;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       chunk_last;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_out;
        logic [1:0]  status;
        logic [2:0]  error_code;
        logic [2:0]  method_code;
        logic        version_is_10;
        logic [6:0]  header_total;
        logic [31:0] body_length;
        logic        h2_preface;
    } rsp_t;

    // Result kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_PATH    = 3'd1;
    localparam logic [2:0] KIND_HNAME   = 3'd2;
    localparam logic [2:0] KIND_HVALUE  = 3'd3;
    localparam logic [2:0] KIND_BODY    = 3'd4;
    localparam logic [2:0] KIND_HDR_END = 3'd5;

    // Request status
    localparam logic [1:0] STAT_INCOMPLETE = 2'd0;
    localparam logic [1:0] STAT_COMPLETE   = 2'd1;
    localparam logic [1:0] STAT_ERROR      = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_METHOD   = 3'd1;
    localparam logic [2:0] ERR_NO_PATH  = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG = 3'd3;
    localparam logic [2:0] ERR_NO_COLON = 3'd4;
    localparam logic [2:0] ERR_H2       = 3'd5;

    // Method codes
    localparam logic [2:0] METH_NONE    = 3'd0;
    localparam logic [2:0] METH_GET     = 3'd1;
    localparam logic [2:0] METH_POST    = 3'd2;
    localparam logic [2:0] METH_PUT     = 3'd3;
    localparam logic [2:0] METH_DELETE  = 3'd4;
    localparam logic [2:0] METH_HEAD    = 3'd5;
    localparam logic [2:0] METH_OPTIONS = 3'd6;

    // Register indexes on the configuration port
    localparam logic REG_MAX_LINE_LENGTH = 1'b0;
    localparam logic REG_MAX_HEADERS     = 1'b1;

    localparam logic [15:0] MAX_LINE_LENGTH_RST = 16'd8192;
    localparam logic [6:0]  MAX_HEADERS_RST     = 7'd32;

endpackage

// ===== design/http_request_byte_parser_top.sv =====
// A byte is taken into the input register and parsed from there; its result is
// written to the result register when that register is free to take it.
// One byte per cycle unless a low rsp_ready holds the result register; the per-byte
// state update is a single pass of compares, a token byte insert and one decimal multiply-accumulate.
// Reset (rst_n, asynchronous, active low) empties both stages, restarts the
// request parse and loads max_line_length 8192 and max_headers 32.

// Top level of the HTTP request byte parser: input register, per-byte parse
// logic, result register and APB register file. Depends on hrbp_pkg.

module http_request_byte_parser_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  hrbp_pkg::req_t     req_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output hrbp_pkg::rsp_t     rsp_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [8:0] {
        PH_METHOD  = 9'b000000001,
        PH_PATH    = 9'b000000010,
        PH_VERSION = 9'b000000100,
        PH_HNAME   = 9'b000001000,
        PH_HVALUE  = 9'b000010000,
        PH_BODY    = 9'b000100000,
        PH_DONE    = 9'b001000000,
        PH_ERROR   = 9'b010000000,
        PH_PREFACE = 9'b100000000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] line_count;
        logic [63:0] token_chars;
        logic [3:0]  token_len;
        logic [4:0]  name_match;
        logic        pending_cr;
        logic [3:0]  preface_count;
        logic [2:0]  method_code;
        logic        version;
        logic [6:0]  header_counter;
        logic        skip_header;
        logic [31:0] length;
        logic [31:0] body_count;
        logic [2:0]  err_code;
    } pstate_t;

    typedef struct packed {
        pstate_t    st;
        logic [2:0] kind;
        logic [7:0] data;
    } step_t;

    // Tokens packed first byte in the low byte
    localparam logic [63:0] TOK_GET     = 64'h0000_0000_0054_4547;
    localparam logic [63:0] TOK_POST    = 64'h0000_0000_5453_4F50;
    localparam logic [63:0] TOK_PUT     = 64'h0000_0000_0054_5550;
    localparam logic [63:0] TOK_DELETE  = 64'h0000_4554_454C_4544;
    localparam logic [63:0] TOK_HEAD    = 64'h0000_0000_4441_4548;
    localparam logic [63:0] TOK_OPTIONS = 64'h0053_4E4F_4954_504F;
    localparam logic [63:0] TOK_PRI     = 64'h0000_0000_0049_5250;
    localparam logic [63:0] TOK_HTTP10  = 64'h302E_312F_5054_5448;

    localparam logic [4:0] NM_FULL   = 5'd14;
    localparam logic [4:0] NM_DIGITS = 5'd16;
    localparam logic [4:0] NM_OTHER  = 5'd31;

    localparam logic [3:0] PREFACE_START = 4'd4;
    localparam logic [3:0] PREFACE_END   = 4'd15;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    function automatic logic [7:0] preface_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "P";
            4'd1:    ch = "R";
            4'd2:    ch = "I";
            4'd3:    ch = " ";
            4'd4:    ch = "*";
            4'd5:    ch = " ";
            4'd6:    ch = "H";
            4'd7:    ch = "T";
            4'd8:    ch = "T";
            4'd9:    ch = "P";
            4'd10:   ch = "/";
            4'd11:   ch = "2";
            4'd12:   ch = ".";
            4'd13:   ch = "0";
            4'd14:   ch = CH_CR;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] cl_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic pstate_t start_req();
        pstate_t s;
        s.phase          = PH_METHOD;
        s.line_count     = '0;
        s.token_chars    = '0;
        s.token_len      = '0;
        s.name_match     = '0;
        s.pending_cr     = 1'b0;
        s.preface_count  = '0;
        s.method_code    = hrbp_pkg::METH_NONE;
        s.version        = 1'b0;
        s.header_counter = '0;
        s.skip_header    = 1'b0;
        s.length         = '0;
        s.body_count     = '0;
        s.err_code       = hrbp_pkg::ERR_NONE;
        return s;
    endfunction

    function automatic pstate_t tok_add(input pstate_t s, input logic [7:0] c);
        pstate_t r;
        r = s;
        for (int i = 0; i < 8; i++)
        begin
            if (s.token_len == 4'(i))
            begin
                r.token_chars[8*i +: 8] = s.token_chars[8*i +: 8] | c;
            end
        end
        if (s.token_len != 4'd15)
        begin
            r.token_len = s.token_len + 4'd1;
        end
        return r;
    endfunction

    function automatic logic tok_is(input pstate_t s, input logic [63:0] val,
                                    input logic [3:0] n);
        return (s.token_len == n) && (s.token_chars == val);
    endfunction

    function automatic pstate_t start_hdr(input pstate_t s, input logic [6:0] max_hdr);
        pstate_t r;
        r = s;
        r.phase       = PH_HNAME;
        r.line_count  = '0;
        r.token_len   = '0;
        r.name_match  = '0;
        r.skip_header = (s.header_counter >= max_hdr);
        return r;
    endfunction

    // One byte of line content
    function automatic step_t do_content(input pstate_t s, input logic [7:0] ch,
                                         input logic [15:0] lim);
        step_t       r;
        logic [7:0]  c;
        logic [35:0] acc;
        r.st   = s;
        r.kind = hrbp_pkg::KIND_NONE;
        r.data = 8'h00;
        c      = ch;
        acc    = '0;
        if ({1'b0, s.line_count} + 17'd1 >= {1'b0, lim})
        begin
            r.st.phase    = PH_ERROR;
            r.st.err_code = hrbp_pkg::ERR_TOO_LONG;
        end
        else
        begin
            r.st.line_count = s.line_count + 16'd1;
            case (s.phase)
                PH_METHOD:
                begin
                    if (c != CH_SPACE)
                    begin
                        r.st = tok_add(r.st, c);
                    end
                    else if (tok_is(s, TOK_PRI, 4'd3))
                    begin
                        r.st.phase         = PH_PREFACE;
                        r.st.preface_count = PREFACE_START;
                    end
                    else
                    begin
                        r.st.phase = PH_PATH;
                        if (tok_is(s, TOK_GET, 4'd3))
                            r.st.method_code = hrbp_pkg::METH_GET;
                        else if (tok_is(s, TOK_POST, 4'd4))
                            r.st.method_code = hrbp_pkg::METH_POST;
                        else if (tok_is(s, TOK_PUT, 4'd3))
                            r.st.method_code = hrbp_pkg::METH_PUT;
                        else if (tok_is(s, TOK_DELETE, 4'd6))
                            r.st.method_code = hrbp_pkg::METH_DELETE;
                        else if (tok_is(s, TOK_HEAD, 4'd4))
                            r.st.method_code = hrbp_pkg::METH_HEAD;
                        else if (tok_is(s, TOK_OPTIONS, 4'd7))
                            r.st.method_code = hrbp_pkg::METH_OPTIONS;
                        else
                        begin
                            r.st.phase    = PH_ERROR;
                            r.st.err_code = hrbp_pkg::ERR_METHOD;
                        end
                    end
                end
                PH_PATH:
                begin
                    if (c == CH_SPACE)
                    begin
                        r.st.phase       = PH_VERSION;
                        r.st.token_chars = '0;
                        r.st.token_len   = '0;
                    end
                    else
                    begin
                        r.kind = hrbp_pkg::KIND_PATH;
                        r.data = c;
                    end
                end
                PH_VERSION:
                begin
                    r.st = tok_add(r.st, c);
                end
                PH_HNAME:
                begin
                    if (c == CH_COLON)
                    begin
                        r.st.phase     = PH_HVALUE;
                        r.st.token_len = '0;
                        r.st.name_match = NM_OTHER;
                        if (!s.skip_header)
                        begin
                            r.st.header_counter = s.header_counter + 7'd1;
                            if (s.name_match == NM_FULL)
                            begin
                                r.st.length     = '0;
                                r.st.name_match = NM_DIGITS;
                            end
                        end
                    end
                    else
                    begin
                        if (c inside {["A":"Z"]})
                        begin
                            c = c + 8'd32;
                        end
                        if (s.name_match < NM_FULL && c == cl_char(s.name_match[3:0]))
                            r.st.name_match = s.name_match + 5'd1;
                        else
                            r.st.name_match = NM_OTHER;
                        if (!s.skip_header)
                        begin
                            r.kind = hrbp_pkg::KIND_HNAME;
                            r.data = c;
                        end
                    end
                end
                PH_HVALUE:
                begin
                    // Drop leading spaces of the value
                    if (!(s.token_len == 4'd0 && c == CH_SPACE))
                    begin
                        r.st.token_len = 4'd1;
                        if (!s.skip_header)
                        begin
                            r.kind = hrbp_pkg::KIND_HVALUE;
                            r.data = c;
                            if (s.name_match == NM_DIGITS)
                            begin
                                if (c inside {["0":"9"]})
                                begin
                                    acc = ({4'b0, s.length} << 3) + ({4'b0, s.length} << 1)
                                        + 36'(c - 8'h30);
                                    r.st.length = (acc[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                       : acc[31:0];
                                end
                                else
                                begin
                                    r.st.name_match = NM_OTHER;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    r.st = r.st;
                end
            endcase
        end
        return r;
    endfunction

    // CR LF seen
    function automatic step_t do_line_end(input pstate_t s, input logic [15:0] lim,
                                          input logic [6:0] max_hdr);
        step_t r;
        r.st   = s;
        r.kind = hrbp_pkg::KIND_NONE;
        r.data = 8'h00;
        if (s.line_count >= lim)
        begin
            r.st.phase    = PH_ERROR;
            r.st.err_code = hrbp_pkg::ERR_TOO_LONG;
        end
        else
        begin
            case (s.phase)
                PH_METHOD:
                begin
                    r.st.phase    = PH_ERROR;
                    r.st.err_code = hrbp_pkg::ERR_METHOD;
                end
                PH_PATH:
                begin
                    r.st.phase    = PH_ERROR;
                    r.st.err_code = hrbp_pkg::ERR_NO_PATH;
                end
                PH_VERSION:
                begin
                    r.st         = start_hdr(s, max_hdr);
                    r.st.version = tok_is(s, TOK_HTTP10, 4'd8);
                end
                PH_HNAME:
                begin
                    if (s.line_count != 16'd0)
                    begin
                        r.st.phase    = PH_ERROR;
                        r.st.err_code = hrbp_pkg::ERR_NO_COLON;
                    end
                    else
                    begin
                        r.kind     = hrbp_pkg::KIND_HDR_END;
                        r.st.phase = (s.length != 32'd0) ? PH_BODY : PH_DONE;
                    end
                end
                PH_HVALUE:
                begin
                    r.st = start_hdr(s, max_hdr);
                end
                default:
                begin
                    r.st = s;
                end
            endcase
        end
        return r;
    endfunction

    // Configuration registers
    logic [15:0] max_line_length_reg;
    logic [6:0]  max_headers_reg;
    logic        cfg_write;
    logic [15:0] line_limit;

    // Pipeline registers
    logic           s1_valid_reg;
    hrbp_pkg::req_t s1_data_reg;
    logic           rsp_valid_reg;
    hrbp_pkg::rsp_t rsp_data_reg;
    logic           advance;

    // Parse state
    pstate_t state_reg;
    pstate_t state_next;
    logic    drop_rest_reg;
    logic    drop_rest_next;
    hrbp_pkg::rsp_t rsp_next;

    // Scratch for the per-byte pass
    step_t      sr;
    logic [7:0] b;
    logic       last;
    logic       go;
    logic       held;
    logic [2:0] kind_w;
    logic [7:0] data_w;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == hrbp_pkg::REG_MAX_HEADERS) ? {25'd0, max_headers_reg}
                                                                : {16'd0, max_line_length_reg};
    assign line_limit = (max_line_length_reg != 16'd0) ? max_line_length_reg - 16'd1 : 16'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_length_reg <= hrbp_pkg::MAX_LINE_LENGTH_RST;
            max_headers_reg     <= hrbp_pkg::MAX_HEADERS_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == hrbp_pkg::REG_MAX_HEADERS)
                max_headers_reg <= pwdata[6:0];
            else
                max_line_length_reg <= pwdata[15:0];
        end
    end

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        b          = s1_data_reg.byte_in;
        last       = s1_data_reg.chunk_last;
        state_next = state_reg;
        drop_rest_next = drop_rest_reg;
        kind_w     = hrbp_pkg::KIND_NONE;
        data_w     = 8'h00;
        held       = 1'b0;
        go         = 1'b1;
        sr         = '0;

        // After completion or error, drop the rest of the buffer, then start a new request
        if (state_next.phase == PH_DONE || state_next.phase == PH_ERROR)
        begin
            if (drop_rest_reg)
            begin
                held = 1'b1;
                if (last)
                    drop_rest_next = 1'b0;
            end
            else
            begin
                state_next = start_req();
            end
        end

        if (!held)
        begin
            if (state_next.phase == PH_PREFACE)
            begin
                if (state_next.preface_count != PREFACE_END
                    && b == preface_char(state_next.preface_count))
                begin
                    state_next.preface_count = state_next.preface_count + 4'd1;
                    if (state_next.preface_count == PREFACE_END)
                    begin
                        state_next.phase    = PH_ERROR;
                        state_next.err_code = hrbp_pkg::ERR_H2;
                    end
                end
                else
                begin
                    state_next.phase    = PH_ERROR;
                    state_next.err_code = hrbp_pkg::ERR_METHOD;
                end
            end
            else if (state_next.phase == PH_BODY)
            begin
                kind_w = hrbp_pkg::KIND_BODY;
                data_w = b;
                state_next.body_count = state_next.body_count + 32'd1;
                if (state_next.body_count >= state_next.length)
                    state_next.phase = PH_DONE;
            end
            else if (state_next.phase inside {PH_METHOD, PH_PATH, PH_VERSION,
                                              PH_HNAME, PH_HVALUE})
            begin
                if (state_next.pending_cr)
                begin
                    state_next.pending_cr = 1'b0;
                    if (b == CH_LF)
                    begin
                        sr         = do_line_end(state_next, line_limit, max_headers_reg);
                        state_next = sr.st;
                        kind_w     = sr.kind;
                        go         = 1'b0;
                    end
                    else
                    begin
                        // Lone CR is content but never forwarded
                        sr         = do_content(state_next, CH_CR, line_limit);
                        state_next = sr.st;
                        if (!(state_next.phase inside {PH_METHOD, PH_PATH, PH_VERSION,
                                                       PH_HNAME, PH_HVALUE}))
                            go = 1'b0;
                    end
                end
                if (go)
                begin
                    if (b == CH_CR)
                    begin
                        state_next.pending_cr = 1'b1;
                    end
                    else
                    begin
                        sr         = do_content(state_next, b, line_limit);
                        state_next = sr.st;
                        kind_w     = sr.kind;
                        data_w     = sr.data;
                    end
                end
            end

            if (state_next.phase == PH_DONE || state_next.phase == PH_ERROR)
                drop_rest_next = !last;
        end

        rsp_next.kind          = kind_w;
        rsp_next.data_out      = data_w;
        rsp_next.status        = (state_next.phase == PH_DONE)  ? hrbp_pkg::STAT_COMPLETE :
                                 (state_next.phase == PH_ERROR) ? hrbp_pkg::STAT_ERROR :
                                                                  hrbp_pkg::STAT_INCOMPLETE;
        rsp_next.error_code    = state_next.err_code;
        rsp_next.method_code   = state_next.method_code;
        rsp_next.version_is_10 = state_next.version;
        rsp_next.header_total  = state_next.header_counter;
        rsp_next.body_length   = state_next.length;
        rsp_next.h2_preface    = (state_next.preface_count == PREFACE_END);
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_valid && req_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_data_reg <= req_data;
        end
    end

    // Parse state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= start_req();
            drop_rest_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            drop_rest_reg <= drop_rest_next;
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A byte processed in the body phase always comes out as a body transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg.phase == PH_BODY |=> rsp_data_reg.kind == hrbp_pkg::KIND_BODY)
    else $error("body byte not forwarded as body transfer");

    // An error status always carries a nonzero error code
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_data_reg.status == hrbp_pkg::STAT_ERROR
            |-> rsp_data_reg.error_code != hrbp_pkg::ERR_NONE)
    else $error("error status without error code");

    // A waiting input byte is kept until the result stage takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_data_reg))
    else $error("input stage lost a byte");

    // The line length limit stops the count below its wrap point
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.line_count != 16'hFFFF)
    else $error("line count overflow");
`endif

endmodule
